// ----- rtl/akm_pkg.sv -----
package akm_pkg;

    localparam int KW_COUNT = 15;
    localparam int KW_TEXT_BITS = 88;

    localparam logic [7:0] LINE_POS_MAX = 8'd255;
    localparam logic [3:0] WORD_LEN_MAX = 4'd15;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NO_DATA = 5'd0;
    localparam cmd_t CMD_UNKNOWN = 5'd1;
    localparam cmd_t CMD_AMBIGUOUS = 5'd2;
    localparam cmd_t CMD_NAME_NEEDED = 5'd3;
    localparam cmd_t CMD_KW_BASE = 5'd4;
    localparam cmd_t CMD_KW_LAST = 5'd18;

    // keyword text, right-justified: first char in the highest used byte
    localparam logic [KW_TEXT_BITS-1:0] KW_STR [KW_COUNT] = '{
        "help", "name", "game", "who", "games", "challenges", "challenge",
        "recall", "accept", "reject", "move", "board", "resign", "tell", "quit"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd4, 4'd4, 4'd3, 4'd5, 4'd10, 4'd9, 4'd6, 4'd6, 4'd6,
        4'd4, 4'd5, 4'd6, 4'd4, 4'd4
    };
    // bit k set: keyword k needs a name
    localparam logic [KW_COUNT-1:0] KW_NEEDS = 15'b011111111100100;

    typedef struct packed {
        logic [KW_COUNT-1:0] alive;
        logic [3:0]          word_len;
        logic                named;
    } pick_in_t;

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [KW_TEXT_BITS-1:0] shifted;
        shifted = KW_STR[k] >> ((int'(KW_LEN[k]) - 1 - int'(i)) * 8);
        return shifted[7:0];
    endfunction

    function automatic logic [7:0] pos_inc(input logic [7:0] p);
        return (p == LINE_POS_MAX) ? p : p + 8'd1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

// ----- rtl/akm_pick.sv -----
module akm_pick (
    input  akm_pkg::pick_in_t pick_in,
    output akm_pkg::cmd_t     command
);
    import akm_pkg::*;

    logic [KW_COUNT-1:0] exact;
    logic [KW_COUNT-1:0] prefix;
    logic                exact_any;
    logic [3:0]          exact_idx;
    logic [3:0]          prefix_idx;
    logic                prefix_multi;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            exact[k]  = pick_in.alive[k] && (KW_LEN[k] == pick_in.word_len);
            prefix[k] = pick_in.alive[k] && (KW_LEN[k] > pick_in.word_len);
        end
    end

    // lowest set index wins: scan from the top down
    always_comb
    begin
        exact_idx  = '0;
        prefix_idx = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (exact[k])
            begin
                exact_idx = 4'(k);
            end
            if (prefix[k])
            begin
                prefix_idx = 4'(k);
            end
        end
    end

    assign exact_any = |exact;
    assign prefix_multi = |(prefix & (prefix - KW_COUNT'(1)));

    always_comb
    begin
        if (exact_any)
        begin
            if (KW_NEEDS[exact_idx] && !pick_in.named)
            begin
                command = CMD_NAME_NEEDED;
            end
            else
            begin
                command = CMD_KW_BASE + cmd_t'(exact_idx);
            end
        end
        else if (prefix == '0)
        begin
            command = CMD_UNKNOWN;
        end
        else if (prefix_multi)
        begin
            command = CMD_AMBIGUOUS;
        end
        else
        begin
            command = CMD_KW_BASE + cmd_t'(prefix_idx);
        end
    end

endmodule

// ----- rtl/abbreviated_keyword_matcher.sv -----
// The result is registered: it appears in the cycle after the item that ends its line
// (newline, or an item with tlast) is accepted.
// Throughput: one item per cycle; keyword compares for all 15 entries run in
// parallel on each item. Input stalls only while a result is held and
// m_axis_tready is low.
// Reset (rst_n low, asynchronous): line state is cleared and no result is held.
module abbreviated_keyword_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tuser,   // [0] name_given
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [4:0] command, [12:5] rest_start,
                                        // [20:13] rest_length, [23:21] zero
    output logic        m_axis_tuser    // [0] ended_by_newline
);
    import akm_pkg::*;

    typedef enum logic [1:0] {
        PH_BEFORE,
        PH_IN,
        PH_AFTER
    } phase_t;

    phase_t              phase_reg, phase_upd;
    logic [KW_COUNT-1:0] alive_reg, alive_upd;
    logic [3:0]          wlen_reg, wlen_upd;
    logic [7:0]          pos_reg, pos_upd;
    logic [7:0]          roff_reg, roff_upd;
    logic [7:0]          lte_reg, lte_upd;

    logic                out_valid_reg;
    cmd_t                cmd_reg, cmd_next;
    logic [7:0]          start_reg, start_next;
    logic [7:0]          len_reg, len_next;
    logic                nl_reg;

    logic                s_accept;
    logic                newline;
    logic                blank;
    logic                line_end;
    logic [7:0]          roff_inc;
    pick_in_t            pick_in;
    cmd_t                pick_cmd;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign newline = (s_axis_tdata == CHAR_NEWLINE);
    assign blank = is_blank(s_axis_tdata);
    assign line_end = newline || s_axis_tlast;

    // line state after this item, before any end-of-line clear
    always_comb
    begin
        phase_upd = phase_reg;
        alive_upd = alive_reg;
        wlen_upd  = wlen_reg;
        pos_upd   = pos_reg;
        roff_upd  = roff_reg;
        lte_upd   = lte_reg;
        if (!newline)
        begin
            pos_upd = pos_inc(pos_reg);
            if ((phase_reg == PH_BEFORE && !blank) || (phase_reg == PH_IN && !blank))
            begin
                phase_upd = PH_IN;
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (wlen_reg >= KW_LEN[k] || kw_char(k, wlen_reg) != s_axis_tdata)
                    begin
                        alive_upd[k] = 1'b0;
                    end
                end
                if (wlen_reg != WORD_LEN_MAX)
                begin
                    wlen_upd = wlen_reg + 4'd1;
                end
            end
            else if (phase_reg == PH_IN)
            begin
                phase_upd = PH_AFTER;
                roff_upd  = pos_reg;
                lte_upd   = pos_reg;
            end
            else if (phase_reg == PH_AFTER && !blank)
            begin
                lte_upd = pos_inc(pos_reg);
            end
        end
    end

    assign pick_in = '{alive: alive_upd, word_len: wlen_upd, named: s_axis_tuser};

    akm_pick u_pick (
        .pick_in (pick_in),
        .command (pick_cmd)
    );

    assign roff_inc = pos_inc(roff_upd);

    always_comb
    begin
        cmd_next   = pick_cmd;
        start_next = '0;
        len_next   = '0;
        case (phase_upd)
            PH_BEFORE:
            begin
                cmd_next = CMD_NO_DATA;
            end
            PH_IN:
            begin
                start_next = pos_upd;
            end
            PH_AFTER:
            begin
                if (lte_upd > roff_upd)
                begin
                    start_next = roff_inc;
                    len_next   = (lte_upd > roff_inc) ? lte_upd - roff_inc : 8'd0;
                end
                else
                begin
                    start_next = roff_upd;
                end
            end
            default:
            begin
                cmd_next = CMD_NO_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEFORE;
            alive_reg     <= KW_ALL;
            wlen_reg      <= '0;
            pos_reg       <= '0;
            roff_reg      <= '0;
            lte_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_NO_DATA;
            start_reg     <= '0;
            len_reg       <= '0;
            nl_reg        <= 1'b0;
        end
        else
        begin
            if (s_accept && line_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s_accept)
            begin
                if (line_end)
                begin
                    phase_reg     <= PH_BEFORE;
                    alive_reg     <= KW_ALL;
                    wlen_reg      <= '0;
                    pos_reg       <= '0;
                    roff_reg      <= '0;
                    lte_reg       <= '0;
                    cmd_reg       <= cmd_next;
                    start_reg     <= start_next;
                    len_reg       <= len_next;
                    nl_reg        <= newline;
                end
                else
                begin
                    phase_reg <= phase_upd;
                    alive_reg <= alive_upd;
                    wlen_reg  <= wlen_upd;
                    pos_reg   <= pos_upd;
                    roff_reg  <= roff_upd;
                    lte_reg   <= lte_upd;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, len_reg, start_reg, cmd_reg};
    assign m_axis_tuser  = nl_reg;

`ifndef ASSERT_OFF
    // a line end always returns the matcher to a fresh line
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && line_end |=> phase_reg == PH_BEFORE && alive_reg == KW_ALL)
        else $error("line state not cleared after line end");

    // word length is zero exactly while no word has started
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BEFORE) == (wlen_reg == 4'd0))
        else $error("word length out of step with phase");

    // an empty line carries no rest of line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cmd_reg == CMD_NO_DATA |-> start_reg == 8'd0 && len_reg == 8'd0)
        else $error("no-data result with nonzero rest fields");

    // command code stays within the defined range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> cmd_reg <= CMD_KW_LAST)
        else $error("command code out of range");

    // rest of line never runs past the saturated line end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> 9'(start_reg) + 9'(len_reg) <= 9'(LINE_POS_MAX))
        else $error("rest of line exceeds line length");
`endif

endmodule
